// File: rtl/core/stb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_pkg
// Shared types and constants for the periodic timer bank.
// ----------------------------------------------------------------------------
package stb_pkg;

    localparam int PERIOD_W = 16;
    localparam int COUNT_W  = 18;
    localparam int ENTRY_W  = PERIOD_W + COUNT_W;
    localparam int MASK_W   = 8;

    localparam logic [COUNT_W-1:0] STEP_SHORT = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] STEP_LONG  = COUNT_W'(10);

    localparam logic [2:0] OP_TICK_1MS  = 3'd0;
    localparam logic [2:0] OP_TICK_10MS = 3'd1;
    localparam logic [2:0] OP_ENABLE    = 3'd2;
    localparam logic [2:0] OP_DISABLE   = 3'd3;
    localparam logic [2:0] OP_CONTINUE  = 3'd4;

    typedef struct packed {
        logic [2:0]          opcode;
        logic [2:0]          timer_index;
        logic [PERIOD_W-1:0] period_ms;
    } t_stb_in;

    typedef struct packed {
        logic [MASK_W-1:0] fired_mask;
        logic [MASK_W-1:0] running_mask;
    } t_stb_out;

endpackage

// File: rtl/core/software_timer_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software_timer_bank
// Bank of periodic timers driven by tick, enable, disable and continue
// operations; one fired/running mask result per operation.
// ----------------------------------------------------------------------------
// Timer periods and counts live in one RAM entry per timer. A tick walks
// every entry, one per cycle through the RAM read port, before its result
// is ready; every other operation needs no walk. One operation is in work
// at a time: the next is taken once the last result has moved on into the
// output register. Results sit in that register, so the next operation is
// taken while a result waits.
// Only timers 0 to 7 appear in the masks.
module software_timer_bank import stb_pkg::*; #(
    parameter int NUM_TIMERS = 8
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_stb_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_stb_out o_out_data
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    logic               res_valid;
    logic               res_ready;
    t_stb_out           res;
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic               r_out_valid;
    t_stb_out           r_out_data;

    stb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_TIMERS),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    stb_seq #(
        .NUM_TIMERS (NUM_TIMERS),
        .IW         (IW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_valid && res_ready) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTH
    // a timer that fires keeps running
    a_fired_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.fired_mask & ~o_out_data.running_mask) == '0))
        else $error("fired timer not marked running");

    // one operation in work at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("transfer taken while busy");

    // a result is only handed over when the output register can take it
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("pending result dropped");
`endif

endmodule

// File: rtl/core/stb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module stb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/stb_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_seq
// Operation sequencer: run flags, entry valid bits and the tick walk that
// reads each timer entry and updates and writes back those of running timers.
// ----------------------------------------------------------------------------
module stb_seq import stb_pkg::*; #(
    parameter int NUM_TIMERS = 8,
    parameter int IW         = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_stb_in            i_in_data,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output t_stb_out           o_res,
    output logic               o_ram_we,
    output logic [IW-1:0]      o_ram_waddr,
    output logic [ENTRY_W-1:0] o_ram_wdata,
    output logic [IW-1:0]      o_ram_raddr,
    input  logic [ENTRY_W-1:0] i_ram_rdata
);

    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int PW = (NUM_TIMERS > MASK_W) ? NUM_TIMERS : MASK_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_TICK = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_p_vld, n_p_vld;
    logic [IW-1:0]         r_p_idx, n_p_idx;
    logic [COUNT_W-1:0]    r_step, n_step;
    logic [NUM_TIMERS-1:0] r_fired, n_fired;
    logic [NUM_TIMERS-1:0] r_run, n_run;
    logic [NUM_TIMERS-1:0] r_ent_vld, n_ent_vld;

    logic                  idx_ok;
    logic [IW-1:0]         idx_w;
    logic [ENTRY_W-1:0]    ent;
    logic [PERIOD_W-1:0]   ent_period;
    logic [COUNT_W-1:0]    ent_count;
    logic [COUNT_W-1:0]    new_count;
    logic [PW-1:0]         fired_pad;
    logic [PW-1:0]         run_pad;

    assign idx_ok     = {29'd0, i_in_data.timer_index} < 32'(NUM_TIMERS);
    assign idx_w      = IW'(i_in_data.timer_index);
    assign ent        = r_ent_vld[r_p_idx] ? i_ram_rdata : '0;
    assign ent_period = ent[ENTRY_W-1:COUNT_W];
    assign ent_count  = ent[COUNT_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_p_vld     = 1'b0;
        n_p_idx     = r_p_idx;
        n_step      = r_step;
        n_fired     = r_fired;
        n_run       = r_run;
        n_ent_vld   = r_ent_vld;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_p_idx;
        o_ram_wdata = '0;
        o_ram_raddr = r_cnt[IW-1:0];
        new_count   = ent_count - r_step;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_fired = '0;
                    n_state = S_DONE;
                    case (i_in_data.opcode)
                        OP_TICK_1MS: begin
                            n_step  = STEP_SHORT;
                            n_cnt   = '0;
                            n_state = S_TICK;
                        end
                        OP_TICK_10MS: begin
                            n_step  = STEP_LONG;
                            n_cnt   = '0;
                            n_state = S_TICK;
                        end
                        OP_ENABLE: begin
                            if (idx_ok) begin
                                o_ram_we         = 1'b1;
                                o_ram_waddr      = idx_w;
                                o_ram_wdata      = {i_in_data.period_ms,
                                    {2'b00, i_in_data.period_ms} - COUNT_W'(1)};
                                n_ent_vld[idx_w] = 1'b1;
                                n_run[idx_w]     = 1'b1;
                            end
                        end
                        OP_DISABLE: begin
                            if (idx_ok) begin
                                n_run[idx_w] = 1'b0;
                            end
                        end
                        OP_CONTINUE: begin
                            if (idx_ok) begin
                                n_run[idx_w] = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_TICK: begin
                if (r_cnt < CW'(NUM_TIMERS)) begin
                    n_p_vld = 1'b1;
                    n_p_idx = r_cnt[IW-1:0];
                    n_cnt   = r_cnt + CW'(1);
                end
                if (r_p_vld && r_run[r_p_idx]) begin
                    if (new_count[COUNT_W-1]) begin
                        n_fired[r_p_idx] = 1'b1;
                        new_count = {2'b00, ent_period} - COUNT_W'(1);
                    end
                    o_ram_we             = 1'b1;
                    o_ram_wdata          = {ent_period, new_count};
                    n_ent_vld[r_p_idx]   = 1'b1;
                end
                if (r_cnt == CW'(NUM_TIMERS) && !r_p_vld) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_p_vld   <= 1'b0;
            r_run     <= '0;
            r_ent_vld <= '0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_p_vld   <= n_p_vld;
            r_run     <= n_run;
            r_ent_vld <= n_ent_vld;
        end
        r_p_idx <= n_p_idx;
        r_step  <= n_step;
        r_fired <= n_fired;
    end

    assign fired_pad          = PW'(r_fired);
    assign run_pad            = PW'(r_run);
    assign o_in_ready         = (r_state == S_IDLE);
    assign o_res_valid        = (r_state == S_DONE);
    assign o_res.fired_mask   = fired_pad[MASK_W-1:0];
    assign o_res.running_mask = run_pad[MASK_W-1:0];

endmodule

// File: tb/software_timer_bank_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software_timer_bank_checker
// Watches both channels of the timer bank. Each input transfer is run
// through a shadow copy of the periods, counts and run flags to predict its
// fired and running masks; each output transfer is compared with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module software_timer_bank_checker import stb_pkg::*; #(
    parameter int NUM_TIMERS = 8
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_ready,
    input  t_stb_in  i_in_data,
    input  logic     i_out_valid,
    input  logic     i_out_ready,
    input  t_stb_out i_out_data,
    output int       o_fail_count,
    output int       o_pending
);

    logic [PERIOD_W-1:0]        period_q [NUM_TIMERS];
    logic signed [COUNT_W-1:0]  count_q  [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]      run_q;
    t_stb_out                   pending_masks [$];
    int                         fail_count = 0;
    int                         pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic t_stb_out predict_masks(input t_stb_in op);
        t_stb_out                  res;
        logic [COUNT_W-1:0]        step;
        logic signed [COUNT_W-1:0] next_count;
        logic [NUM_TIMERS-1:0]     fired;
        logic                      idx_ok;
        fired  = '0;
        idx_ok = int'(op.timer_index) < NUM_TIMERS;
        step   = (op.opcode == OP_TICK_1MS) ? STEP_SHORT : STEP_LONG;
        case (op.opcode)
            OP_TICK_1MS, OP_TICK_10MS: begin
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (run_q[i]) begin
                        next_count = count_q[i] - $signed(step);
                        if (next_count[COUNT_W-1]) begin
                            fired[i]   = 1'b1;
                            next_count = $signed({2'b00, period_q[i]} - COUNT_W'(1));
                        end
                        count_q[i] = next_count;
                    end
                end
            end
            OP_ENABLE: begin
                if (idx_ok) begin
                    period_q[op.timer_index] = op.period_ms;
                    count_q[op.timer_index]  = $signed({2'b00, op.period_ms} - COUNT_W'(1));
                    run_q[op.timer_index]    = 1'b1;
                end
            end
            OP_DISABLE: begin
                if (idx_ok) run_q[op.timer_index] = 1'b0;
            end
            OP_CONTINUE: begin
                if (idx_ok) run_q[op.timer_index] = 1'b1;
            end
            default: ;
        endcase
        res.fired_mask   = MASK_W'(fired);
        res.running_mask = MASK_W'(run_q);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_stb_out want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                period_q[i] = '0;
                count_q[i]  = '0;
            end
            run_q = '0;
            pending_masks.delete();
        end else begin
            // older result leaves first, so a transfer on both sides pairs correctly
            if (i_out_valid && i_out_ready) begin
                if (pending_masks.size() == 0) begin
                    report_mismatch($sformatf("result %h with nothing expected", i_out_data));
                end else begin
                    want = pending_masks.pop_front();
                    if (i_out_data.fired_mask !== want.fired_mask)
                        report_mismatch($sformatf("fired_mask %h, want %h",
                                                  i_out_data.fired_mask, want.fired_mask));
                    if (i_out_data.running_mask !== want.running_mask)
                        report_mismatch($sformatf("running_mask %h, want %h",
                                                  i_out_data.running_mask, want.running_mask));
                end
            end
            if (i_in_valid && i_in_ready)
                pending_masks.push_back(predict_masks(i_in_data));
        end
        pending_count = pending_masks.size();
    end

endmodule

// File: tb/software_timer_bank_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software_timer_bank_tb
// Drives the timer bank with a directed set of operations (period extremes,
// pause and continue, never-enabled timers, unused opcodes) and then random
// operation streams with random idle bursts on both channels. Checking is
// done by the checker instance; this module makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module software_timer_bank_tb;
    import stb_pkg::*;

    localparam int         NUM_TIMERS      = 8;
    localparam int         RANDOM_ITEMS    = 700;
    localparam int         QUIET_FROM      = 600;
    localparam int         DRAIN_EVERY     = 150;
    localparam int         DRAIN_CYCLES    = 20;
    localparam int         LIMIT_CYCLES    = 200000;
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_MID   = 3'd6;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    t_stb_in  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    t_stb_out out_data;

    int       fail_count;
    int       pending;
    int       cycles     = 0;
    int       stall_left = 0;
    bit       quiet      = 1'b0;

    always #1 clk = ~clk;

    software_timer_bank #(
        .NUM_TIMERS (NUM_TIMERS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    software_timer_bank_checker #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("software_timer_bank_tb failed");
            $finish;
        end
    end

    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 4) - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // called right after a falling edge; returns on the falling edge after the transfer
    task automatic send_op(input logic [2:0] op, input logic [2:0] idx,
                           input logic [PERIOD_W-1:0] period);
        t_stb_in item;
        item.opcode      = op;
        item.timer_index = idx;
        item.period_ms   = period;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    function automatic logic [2:0] pick_opcode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return OP_TICK_1MS;
        if (r < 55) return OP_TICK_10MS;
        if (r < 72) return OP_ENABLE;
        if (r < 84) return OP_DISABLE;
        if (r < 95) return OP_CONTINUE;
        return 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
    endfunction

    function automatic logic [PERIOD_W-1:0] pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return PERIOD_W'($urandom_range(0, 25));
        if (r < 90) return PERIOD_W'($urandom_range(0, 300));
        return PERIOD_W'($urandom_range(0, 65535));
    endfunction

    initial begin
        logic [2:0] op;
        int         counted;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // never-enabled timer: period and count zero, fires every tick
        send_op(OP_CONTINUE,  3'd5, 16'd0);
        send_op(OP_TICK_1MS,  3'd0, 16'd0);
        send_op(OP_TICK_10MS, 3'd0, 16'd0);
        send_op(OP_ENABLE,    3'd0, 16'd0);
        send_op(OP_ENABLE,    3'd1, 16'd1);
        send_op(OP_ENABLE,    3'd2, 16'd10);
        send_op(OP_ENABLE,    3'd3, 16'hFFFF);
        send_op(OP_ENABLE,    3'd7, 16'd11);
        send_op(OP_TICK_1MS,  3'd7, 16'hFFFF);
        send_op(OP_TICK_10MS, 3'd0, 16'd0);
        send_op(OP_TICK_10MS, 3'd0, 16'd0);
        send_op(OP_DISABLE,   3'd2, 16'd0);
        send_op(OP_TICK_10MS, 3'd0, 16'd0);
        send_op(OP_CONTINUE,  3'd2, 16'd0);
        send_op(OP_TICK_1MS,  3'd0, 16'd0);
        send_op(OP_UNUSED_FIRST, 3'd2, 16'hAAAA);
        send_op(OP_UNUSED_MID,   3'd5, 16'h5555);
        send_op(OP_UNUSED_LAST,  3'd7, 16'hFFFF);
        send_op(OP_DISABLE,   3'd5, 16'd0);
        send_op(OP_DISABLE,   3'd0, 16'd0);
        send_op(OP_ENABLE,    3'd6, 16'h5555);
        send_op(OP_ENABLE,    3'd4, 16'hAAAA);
        send_op(OP_TICK_1MS,  3'd0, 16'd0);
        send_op(OP_DISABLE,   3'd3, 16'd0);
        send_op(OP_DISABLE,   3'd3, 16'd0);

        hold_until_drained();

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            quiet = counted >= QUIET_FROM;
            op    = pick_opcode();
            send_op(op, 3'($urandom_range(0, 7)), pick_period());
            if (op <= OP_CONTINUE) begin
                counted++;
                if (counted % DRAIN_EVERY == 0) hold_until_drained();
            end
        end

        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("software_timer_bank_tb passed");
        end else begin
            $display("software_timer_bank_tb failed");
        end
        $finish;
    end

endmodule

// File: software_timer_bank.f
rtl/core/stb_pkg.sv
rtl/core/stb_ram.sv
rtl/core/stb_seq.sv
rtl/core/software_timer_bank.sv
tb/software_timer_bank_checker.sv
tb/software_timer_bank_tb.sv
